// ----- sv/vra_pkg.sv -----
// shared types, codes and helpers for the vector run allocator
package vra_pkg;

    localparam int VEC_W   = 8;
    localparam int CPU_W   = 4;
    localparam int CNT_W   = 5;
    localparam int WORD_W  = 64;
    localparam int WORDS   = 4;
    localparam int CHUNK_W = 8;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_FREE    = 3'd1,
        CMD_RESERVE = 3'd2,
        CMD_TEST    = 3'd3,
        CMD_REINIT  = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_NONE = 2'd1,
        STAT_BAD  = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SRD,
        ST_SLD,
        ST_SSCAN,
        ST_RRD,
        ST_RMOD,
        ST_FIN
    } state_e;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [CPU_W-1:0] cpu;
        logic [VEC_W-1:0] first;
        logic [VEC_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [CPU_W-1:0] cpu;
        logic [VEC_W-1:0] vec;
    } res_t;

    // map word after reset: only the second word (0x40-0x7f) is free
    function automatic logic [WORD_W-1:0] reset_word(input logic [1:0] widx);
        reset_word = (widx == 2'd1) ? '0 : '1;
    endfunction

    function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [5:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                idx = 6'(i);
            end
        end
        lowest_set = idx;
    endfunction

endpackage

// ----- sv/vra_ram.sv -----
// generic single-port-write, registered-read ram
module vra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/vra_ctrl.sv -----
// command sequencer: search, range update, test and reinit over the map memory
module vra_ctrl #(
    parameter int MAX_CPUS = 16,
    parameter int CW       = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1,
    parameter int AW       = CW + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  vra_pkg::item_t           item,
    input  logic [vra_pkg::CNT_W-1:0] cpu_count,
    output logic                     res_valid,
    input  logic                     res_ready,
    output vra_pkg::res_t            res,
    output logic                     ram_we,
    output logic [AW-1:0]            ram_waddr,
    output logic [vra_pkg::WORD_W-1:0] ram_wdata,
    output logic [AW-1:0]            ram_raddr,
    input  logic [vra_pkg::WORD_W-1:0] ram_rdata
);
    import vra_pkg::*;

    localparam int NW    = $clog2(MAX_CPUS + 1);
    localparam int DEPTH = MAX_CPUS * WORDS;

    state_e            state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [CW-1:0]     cur_reg, cur_next;
    logic [CPU_W-1:0]  start_reg, start_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     i_reg, i_next;
    logic [1:0]        widx_reg, widx_next;
    logic [2:0]        chunk_reg, chunk_next;
    logic [8:0]        run_reg, run_next;
    logic [VEC_W-1:0]  count_reg, count_next;
    logic [VEC_W-1:0]  lo_reg, lo_next;
    logic [VEC_W-1:0]  last_reg, last_next;
    logic [WORD_W-1:0] word_reg, word_next;
    res_t              res_reg, res_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic              rd_valid_reg;

    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] mask;
    logic [5:0]        lo_b, hi_b;
    logic [8:0]        range_sum;
    logic [NW-1:0]     n_eff;
    logic              cpu_oob;
    logic              hit;
    logic [VEC_W-1:0]  hit_v;
    logic [8:0]        scan_run;
    logic [8:0]        s_full;
    logic              last_word;

    assign rd_word   = rd_valid_reg ? ram_rdata : reset_word(widx_reg);
    assign ram_raddr = {cur_reg, widx_reg};
    assign cpu_oob   = 32'(item.cpu) >= MAX_CPUS;
    assign n_eff     = (32'(cpu_count) > MAX_CPUS) ? NW'(MAX_CPUS) : NW'(cpu_count);
    assign range_sum = {1'b0, item.first} + {1'b0, item.count} - 9'd1;
    assign last_word = (widx_reg == last_reg[7:6]);

    // bits of the current word that lie inside [lo, last]
    assign lo_b = (widx_reg == lo_reg[7:6]) ? lo_reg[5:0] : 6'd0;
    assign hi_b = last_word ? last_reg[5:0] : 6'd63;
    assign mask = ({WORD_W{1'b1}} << lo_b) & ({WORD_W{1'b1}} >> (6'd63 - hi_b));

    // eight bits of the free-run scan per cycle
    always_comb
    begin
        logic [8:0] r;
        logic       h;
        logic [VEC_W-1:0] hv;
        r  = run_reg;
        h  = 1'b0;
        hv = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            r = word_reg[{chunk_reg, 3'(i)}] ? 9'd0 : r + 9'd1;
            if (!h && r == {1'b0, count_reg})
            begin
                h  = 1'b1;
                hv = {widx_reg, chunk_reg, 3'(i)};
            end
        end
        scan_run = r;
        hit      = h;
        hit_v    = hv;
    end

    assign s_full = {1'b0, hit_v} + 9'd1 - {1'b0, count_reg};

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        widx_next  = widx_reg;
        chunk_next = chunk_reg;
        run_next   = run_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        last_next  = last_reg;
        word_next  = word_reg;
        res_next   = res_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd_next   = item.cmd;
                    cur_next   = CW'(item.cpu);
                    start_next = item.cpu;
                    n_next     = n_eff;
                    count_next = item.count;
                    lo_next    = item.first;
                    last_next  = range_sum[8] ? 8'hFF : range_sum[7:0];
                    widx_next  = item.first[7:6];
                    res_next   = '0;
                    state_next = ST_FIN;
                    if (item.cmd <= CMD_TEST && item.count == '0)
                    begin
                        res_next.status = STAT_BAD;
                    end
                    else
                    begin
                        priority case (item.cmd)
                            CMD_ALLOC:
                            begin
                                if (n_eff == '0)
                                begin
                                    res_next.status = STAT_NONE;
                                end
                                else
                                begin
                                    state_next = ST_MOD;
                                end
                            end
                            CMD_FREE, CMD_RESERVE:
                            begin
                                if (!cpu_oob)
                                begin
                                    state_next = ST_RRD;
                                end
                            end
                            CMD_TEST:
                            begin
                                if (cpu_oob)
                                begin
                                    res_next.status = STAT_NONE;
                                end
                                else
                                begin
                                    state_next = ST_RRD;
                                end
                            end
                            CMD_REINIT:
                            begin
                                if (!cpu_oob)
                                begin
                                    for (int w = 0; w < WORDS; w++)
                                    begin
                                        valid_next[{CW'(item.cpu), 2'(w)}] = 1'b0;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_MOD:
            begin
                // start cpu modulo cpu count by repeated subtraction
                if (32'(start_reg) >= 32'(n_reg))
                begin
                    start_next = start_reg - CPU_W'(n_reg);
                end
                else
                begin
                    cur_next   = CW'(start_reg);
                    i_next     = '0;
                    run_next   = '0;
                    widx_next  = '0;
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SLD;
            end
            ST_SLD:
            begin
                word_next  = rd_word;
                chunk_next = '0;
                state_next = ST_SSCAN;
            end
            ST_SSCAN:
            begin
                run_next   = scan_run;
                chunk_next = chunk_reg + 3'd1;
                if (hit)
                begin
                    cmd_next   = CMD_RESERVE;
                    lo_next    = s_full[7:0];
                    last_next  = hit_v;
                    widx_next  = s_full[7:6];
                    res_next   = '{status: STAT_OK, cpu: CPU_W'(cur_reg), vec: s_full[7:0]};
                    state_next = ST_RRD;
                end
                else if (chunk_reg == 3'd7)
                begin
                    if (widx_reg == 2'd3)
                    begin
                        if (32'(i_reg) + 1 == 32'(n_reg))
                        begin
                            res_next.status = STAT_NONE;
                            state_next      = ST_FIN;
                        end
                        else
                        begin
                            i_next     = i_reg + NW'(1);
                            cur_next   = (32'(cur_reg) + 1 == 32'(n_reg)) ? '0 : cur_reg + CW'(1);
                            run_next   = '0;
                            widx_next  = '0;
                            state_next = ST_SRD;
                        end
                    end
                    else
                    begin
                        widx_next  = widx_reg + 2'd1;
                        state_next = ST_SRD;
                    end
                end
            end
            ST_RRD:
            begin
                state_next = ST_RMOD;
            end
            ST_RMOD:
            begin
                if (cmd_reg == CMD_TEST)
                begin
                    if ((rd_word & mask) != '0)
                    begin
                        res_next.status = STAT_OK;
                        res_next.vec    = {widx_reg, lowest_set(rd_word & mask)};
                        state_next      = ST_FIN;
                    end
                    else if (last_word)
                    begin
                        res_next.status = STAT_NONE;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        widx_next  = widx_reg + 2'd1;
                        state_next = ST_RRD;
                    end
                end
                else
                begin
                    valid_next[{cur_reg, widx_reg}] = 1'b1;
                    if (last_word)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        widx_next  = widx_reg + 2'd1;
                        state_next = ST_RRD;
                    end
                end
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        res_valid  = (state_reg == ST_FIN);
        res        = res_reg;
        ram_we     = (state_reg == ST_RMOD) && (cmd_reg != CMD_TEST);
        ram_waddr  = {cur_reg, widx_reg};
        ram_wdata  = (cmd_reg == CMD_FREE) ? (rd_word & ~mask) : (rd_word | mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cur_reg      <= cur_next;
        start_reg    <= start_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        widx_reg     <= widx_next;
        chunk_reg    <= chunk_next;
        run_reg      <= run_next;
        count_reg    <= count_next;
        lo_reg       <= lo_next;
        last_reg     <= last_next;
        word_reg     <= word_next;
        res_reg      <= res_next;
        rd_valid_reg <= valid_reg[ram_raddr];
    end

endmodule

// ----- sv/per_cpu_vector_run_allocator_unit.sv -----
// top level of the per-cpu vector run allocator
//
// one command item enters on the s_ side, one result item leaves on the m_ side.
// commands: allocate a run of free vectors searching cpus cyclically from a
// start cpu, free a range, reserve a range, test a range for its lowest used
// vector, reinit one cpu map. every item yields exactly one result.
// the maps live in one ram of MAX_CPUS*4 words of 64 bits, one word read and
// written back per step. steps from accept to result:
//   free, reserve, test: a read and a modify step per map word touched (1 to 4 words)
//   allocate: start cpu modulo cpu count by repeated subtraction, then per map
//     word scanned a read, a load and a scan of 8 vectors per cycle (up to 4 words
//     per cpu), then a read and a modify step per word marked
//   bad count, reinit, unknown commands: straight to the result
// the block takes one item at a time; s_tready is high only when idle.
// the result sits in an output register, so the next item is taken while it
// waits; a stalled m_ side holds the block in its final step once a second
// result is ready.
// reset marks every map as after reinit (per-word valid bits, no clearing pass) and
// sets cpu_count to 1. cfg_we writes cpu_count; use it only while idle, the block does not check.
module per_cpu_vector_run_allocator_unit #(
    parameter int MAX_CPUS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[2:0], cpu_index[6:3], first_vector[14:7], vector_count[22:15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], out_cpu[5:2], out_vector[13:6]
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);
    import vra_pkg::*;

    localparam int CW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int AW = CW + 2;

    logic [CNT_W-1:0] cpu_count_reg;
    logic             m_valid_reg;
    res_t             m_res_reg;
    item_t            item;
    res_t             res;
    logic             res_valid;
    logic             res_ready;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    assign item.cmd   = s_tdata[2:0];
    assign item.cpu   = s_tdata[6:3];
    assign item.first = s_tdata[14:7];
    assign item.count = s_tdata[22:15];

    assign res_ready = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_res_reg.vec, m_res_reg.cpu, m_res_reg.status};

    vra_ctrl #(
        .MAX_CPUS (MAX_CPUS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s_tvalid),
        .item_ready (s_tready),
        .item       (item),
        .cpu_count  (cpu_count_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    vra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_CPUS * WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_count_reg <= CNT_W'(1);
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cpu_count_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_res_reg <= res;
        end
    end

endmodule

// ----- sv/vra_checker.sv -----
// port-level checks for the allocator, bound to the top level
module vra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import vra_pkg::*;

    // one item at a time: an accept drops ready next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // a failed or bad item never names a cpu or vector
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != STAT_OK |-> m_tdata[13:2] == 12'd0)
        else $error("failed result carries cpu or vector");

endmodule

bind per_cpu_vector_run_allocator_unit vra_checker u_vra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
